>>> hdl/midi_track_merge_event_parser_macros.svh
// assertion macros for the midi track merge event parser
`ifndef MIDI_TRACK_MERGE_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_MERGE_EVENT_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every edge out of reset
`define MTM_CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// condition holds in the cycle after the antecedent
`define MTM_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MTM_CHK_NOW(lbl, ante, cons, msg)
`define MTM_CHK_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/midtm_pkg.sv
// shared constants, types and helpers of the midi track merge event parser
package midtm_pkg;
	localparam int NUM_TRACKS      = 16;
	localparam int TRACK_BYTES     = 4096;
	localparam int MAX_DELTA_BYTES = 4;

	localparam int TRK_W   = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
	localparam int TCNT_W  = $clog2(NUM_TRACKS + 1);
	localparam int FILL_W  = $clog2(TRACK_BYTES + 1);
	localparam int POS_W   = $clog2(TRACK_BYTES + 270);
	localparam int MEM_DEPTH = NUM_TRACKS * TRACK_BYTES;
	localparam int ADDR_W  = $clog2(MEM_DEPTH);
	localparam int NB_W    = $clog2(MAX_DELTA_BYTES + 1);
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);

	// input commands
	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_APPEND  = 2'd1;
	localparam logic [1:0] CMD_REQUEST = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_SHORT = 2'd0;
	localparam logic [1:0] KIND_TEMPO = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_ERR   = 2'd3;

	typedef struct packed {
		logic [1:0]       op;
		logic [TRK_W-1:0] trk;
		logic [7:0]       data;
	} q_item_t;

	typedef struct packed {
		logic [23:0] tempo_value;
		logic [7:0]  second_data;
		logic [7:0]  first_data;
		logic [7:0]  status_byte;
		logic [3:0]  source_track;
		logic [31:0] delta_time;
	} result_t;

	// track number as the four-bit source field
	function automatic logic [3:0] src4(input logic [TRK_W-1:0] t);
		logic [31:0] x;
		x = 32'(t);
		return x[3:0];
	endfunction
endpackage

>>> hdl/midi_track_merge_event_parser.sv
// An append or clear is carried out as it leaves the queue; a request first starts a scan,
// then reads per track the delta bytes and the event byte (and the type byte of a meta event),
// then carries out the winner; a skipped meta event adds a full rescan.
// Throughput: one item at a time in the sequencer, idle again the cycle after the result transfer.
// Reset (arst_n low) empties every track, zeros times and running status, sets tracks_in_use to 1.
`include "midi_track_merge_event_parser_macros.svh"
module midi_track_merge_event_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // track_index[3:0], data_byte[11:4], zero fill
	input  logic [1:0]  s_axis_tuser,  // command[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,  // delta_time[31:0], source_track[35:32],
	                                   // status_byte[43:36], first_data[51:44],
	                                   // second_data[59:52], tempo_value[83:60], zero fill
	output logic [1:0]  m_axis_tuser,  // event_kind[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data       // tracks_in_use
);
	import midtm_pkg::*;

	q_item_t push_item, pop_item;
	result_t res;
	logic    q_push, q_pop, q_full, q_empty;
	logic    out_end, out_err;

	assign cfg_ready = 1'b1;

	midtm_front u_front (
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_cmd   (s_axis_tuser),
		.s_trk   (s_axis_tdata[3:0]),
		.s_byte  (s_axis_tdata[11:4]),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (push_item)
	);

	midtm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (push_item),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_item (pop_item)
	);

	midtm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.q_empty   (q_empty),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_res   (res)
	);

	assign m_axis_tdata = {4'd0, res};

	// result kinds seen by the checks
	assign out_end = m_axis_tvalid && (m_axis_tuser == KIND_END);
	assign out_err = m_axis_tvalid && (m_axis_tuser == KIND_ERR);

	// queue and result checks
	`MTM_CHK_NOW(a_no_push_full, q_push, !q_full, "push into a full queue")
	`MTM_CHK_NOW(a_no_pop_empty, q_pop, !q_empty, "pop from an empty queue")
	`MTM_CHK_NOW(a_end_zero, out_end, m_axis_tdata == '0, "all-ended result carries data")
	`MTM_CHK_NOW(a_err_fields, out_err, res.delta_time == '0, "error result carries a delta")
endmodule

>>> hdl/midtm_front.sv
// front end: accepts items, drops those without effect, classifies into queue ops
module midtm_front (
	input  logic              s_valid,
	output logic              s_ready,
	input  logic [1:0]        s_cmd,
	input  logic [3:0]        s_trk,
	input  logic [7:0]        s_byte,
	input  logic              q_full,
	output logic              q_push,
	output midtm_pkg::q_item_t q_item
);
	import midtm_pkg::*;

	logic keep;

	// clear and request always go through, append only to an existing track
	always_comb begin
		case (s_cmd)
			CMD_CLEAR, CMD_REQUEST: keep = 1'b1;
			CMD_APPEND:             keep = (32'(s_trk) < NUM_TRACKS);
			default:                keep = 1'b0;
		endcase
	end

	assign s_ready     = !q_full;
	assign q_push      = s_valid && s_ready && keep;
	assign q_item.op   = s_cmd;
	assign q_item.trk  = TRK_W'(s_trk);
	assign q_item.data = s_byte;
endmodule

>>> hdl/midtm_queue.sv
// short queue between the front end and the sequencer
module midtm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  midtm_pkg::q_item_t wr_item,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output midtm_pkg::q_item_t rd_item
);
	import midtm_pkg::*;

	q_item_t            ent_q [QDEPTH];
	logic [QPTR_W-1:0]  wp_q, rp_q;
	logic [QPTR_W:0]    cnt_q;

	assign full    = (32'(cnt_q) == QDEPTH);
	assign empty   = (cnt_q == '0);
	assign rd_item = ent_q[rp_q];

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (32'(wp_q) == QDEPTH - 1) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (32'(rp_q) == QDEPTH - 1) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= wr_item;
	end
endmodule

>>> hdl/midtm_back.sv
// sequencer: track store, per-track state, event scan and result register
module midtm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [4:0]         cfg_data,
	input  logic               q_empty,
	input  midtm_pkg::q_item_t q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_kind,
	output midtm_pkg::result_t out_res
);
	import midtm_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PINIT  = 4'd1;
	localparam logic [3:0] S_RD     = 4'd2;
	localparam logic [3:0] S_DELTA  = 4'd3;
	localparam logic [3:0] S_EVB    = 4'd4;
	localparam logic [3:0] S_META   = 4'd5;
	localparam logic [3:0] S_PEND   = 4'd6;
	localparam logic [3:0] S_XSTART = 4'd7;
	localparam logic [3:0] S_XD1    = 4'd8;
	localparam logic [3:0] S_XNEED  = 4'd9;
	localparam logic [3:0] S_XD2    = 4'd10;
	localparam logic [3:0] S_XLEN   = 4'd11;
	localparam logic [3:0] S_XT0    = 4'd12;
	localparam logic [3:0] S_XT1    = 4'd13;
	localparam logic [3:0] S_XT2    = 4'd14;
	localparam logic [3:0] S_OUT    = 4'd15;

	logic [7:0]        mem [MEM_DEPTH];
	logic [7:0]        rdata_q;
	logic [FILL_W-1:0] fill_q [NUM_TRACKS];
	logic [FILL_W-1:0] rptr_q [NUM_TRACKS];
	logic [31:0]       ttime_q [NUM_TRACKS];
	logic [7:0]        rstat_q [NUM_TRACKS];
	logic [31:0]       last_q;
	logic [4:0]        cfg_q;

	logic [3:0]        state_q, ret_q;
	logic [TRK_W-1:0]  cur_q, w_q;
	logic [TCNT_W-1:0] ntrk_q;
	logic [POS_W-1:0]  rpos_q, evpos_q, bpos_q;
	logic [31:0]       acc_q, best_q;
	logic [NB_W-1:0]   nb_q;
	logic [7:0]        evb_q, meta_q, bev_q, bmeta_q, stat_q, d1_q, a0_q, a1_q;
	logic              ended_q, found_q;

	logic [31:0]       abs_time;
	logic [POS_W-1:0]  skip_next;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic              do_write, do_read;
	logic [31:0]       ntrk_full;

	assign abs_time  = ttime_q[cur_q] + acc_q;
	assign skip_next = bpos_q + POS_W'(3) + POS_W'(rdata_q);
	assign rd_addr   = ADDR_W'(cur_q) * ADDR_W'(TRACK_BYTES) + ADDR_W'(rpos_q);
	assign wr_addr   = ADDR_W'(q_item.trk) * ADDR_W'(TRACK_BYTES)
	                 + ADDR_W'(fill_q[q_item.trk]);
	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign do_write  = q_pop && (q_item.op == CMD_APPEND)
	                 && (32'(fill_q[q_item.trk]) < TRACK_BYTES);
	assign do_read   = (state_q == S_RD);
	assign ntrk_full = (32'(cfg_q) > NUM_TRACKS) ? NUM_TRACKS : 32'(cfg_q);

	// track store
	always_ff @(posedge clk) begin
		if (do_write)
			mem[wr_addr] <= q_item.data;
		if (do_read)
			rdata_q <= mem[rd_addr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cfg_q <= 5'd1;
		else if (cfg_valid)
			cfg_q <= cfg_data;
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			last_q    <= '0;
			out_valid <= 1'b0;
			out_kind  <= KIND_SHORT;
			out_res   <= '0;
			found_q   <= 1'b0;
			cur_q     <= '0;
			w_q       <= '0;
			ntrk_q    <= '0;
			rpos_q    <= '0;
			evpos_q   <= '0;
			bpos_q    <= '0;
			acc_q     <= '0;
			best_q    <= '0;
			nb_q      <= '0;
			evb_q     <= '0;
			meta_q    <= '0;
			bev_q     <= '0;
			bmeta_q   <= '0;
			stat_q    <= '0;
			d1_q      <= '0;
			a0_q      <= '0;
			a1_q      <= '0;
			ended_q   <= 1'b0;
			for (int i = 0; i < NUM_TRACKS; i++) begin
				fill_q[i]  <= '0;
				rptr_q[i]  <= '0;
				ttime_q[i] <= '0;
				rstat_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						out_res <= '0;
						case (q_item.op)
							CMD_CLEAR: begin
								last_q <= '0;
								for (int i = 0; i < NUM_TRACKS; i++) begin
									fill_q[i]  <= '0;
									rptr_q[i]  <= '0;
									ttime_q[i] <= '0;
									rstat_q[i] <= '0;
								end
							end
							CMD_APPEND: begin
								if (do_write)
									fill_q[q_item.trk] <= fill_q[q_item.trk] + 1'b1;
							end
							CMD_REQUEST: begin
								ntrk_q  <= TCNT_W'(ntrk_full);
								cur_q   <= '0;
								found_q <= 1'b0;
								if (ntrk_full == 0) begin
									out_kind  <= KIND_END;
									out_valid <= 1'b1;
									state_q   <= S_OUT;
								end else begin
									state_q <= S_PINIT;
								end
							end
							default: ;
						endcase
					end
				end
				// start decoding the head of the current track
				S_PINIT: begin
					rpos_q  <= POS_W'(rptr_q[cur_q]);
					acc_q   <= '0;
					nb_q    <= '0;
					ret_q   <= S_DELTA;
					state_q <= S_RD;
				end
				// fetch one byte, error past the loaded bytes
				S_RD: begin
					if (rpos_q >= POS_W'(fill_q[cur_q])) begin
						out_kind            <= KIND_ERR;
						out_res.source_track <= src4(cur_q);
						out_valid           <= 1'b1;
						state_q             <= S_OUT;
					end else begin
						state_q <= ret_q;
					end
				end
				// variable-length delta
				S_DELTA: begin
					acc_q  <= (acc_q << 7) + 32'(rdata_q[6:0]);
					rpos_q <= rpos_q + 1'b1;
					nb_q   <= nb_q + 1'b1;
					if (!rdata_q[7]) begin
						ret_q   <= S_EVB;
						state_q <= S_RD;
					end else if (32'(nb_q) + 1 == MAX_DELTA_BYTES) begin
						out_kind            <= KIND_ERR;
						out_res.source_track <= src4(cur_q);
						out_valid           <= 1'b1;
						state_q             <= S_OUT;
					end else begin
						ret_q   <= S_DELTA;
						state_q <= S_RD;
					end
				end
				S_EVB: begin
					evb_q   <= rdata_q;
					evpos_q <= rpos_q;
					meta_q  <= '0;
					ended_q <= 1'b0;
					if (rdata_q == 8'hff) begin
						rpos_q  <= rpos_q + 1'b1;
						ret_q   <= S_META;
						state_q <= S_RD;
					end else begin
						state_q <= S_PEND;
					end
				end
				S_META: begin
					meta_q  <= rdata_q;
					ended_q <= (rdata_q == 8'h2f);
					state_q <= S_PEND;
				end
				// keep the earliest live track, lowest index on ties
				S_PEND: begin
					if (!ended_q && (!found_q || abs_time < best_q)) begin
						found_q <= 1'b1;
						best_q  <= abs_time;
						w_q     <= cur_q;
						bpos_q  <= evpos_q;
						bev_q   <= evb_q;
						bmeta_q <= meta_q;
					end
					if (32'(cur_q) + 1 == 32'(ntrk_q)) begin
						state_q <= S_XSTART;
					end else begin
						cur_q   <= cur_q + 1'b1;
						state_q <= S_PINIT;
					end
				end
				// carry out the winning event
				S_XSTART: begin
					cur_q <= w_q;
					if (!found_q) begin
						out_kind  <= KIND_END;
						out_valid <= 1'b1;
						state_q   <= S_OUT;
					end else if (bev_q == 8'hff) begin
						rpos_q  <= bpos_q + POS_W'(2);
						ret_q   <= S_XLEN;
						state_q <= S_RD;
					end else if (!bev_q[7]) begin
						stat_q <= rstat_q[w_q];
						d1_q   <= bev_q;
						rpos_q <= bpos_q + POS_W'(1);
						if (!rstat_q[w_q][7]) begin
							out_kind            <= KIND_ERR;
							out_res.source_track <= src4(w_q);
							out_valid           <= 1'b1;
							state_q             <= S_OUT;
						end else begin
							state_q <= S_XNEED;
						end
					end else if (bev_q[7:4] == 4'hf) begin
						out_kind            <= KIND_ERR;
						out_res.source_track <= src4(w_q);
						out_valid           <= 1'b1;
						state_q             <= S_OUT;
					end else begin
						stat_q  <= bev_q;
						rpos_q  <= bpos_q + POS_W'(1);
						ret_q   <= S_XD1;
						state_q <= S_RD;
					end
				end
				S_XD1: begin
					d1_q    <= rdata_q;
					rpos_q  <= rpos_q + 1'b1;
					state_q <= S_XNEED;
				end
				// program change and channel pressure take one data byte
				S_XNEED: begin
					if (stat_q[7:4] == 4'hc || stat_q[7:4] == 4'hd) begin
						rstat_q[w_q]         <= stat_q;
						ttime_q[w_q]         <= best_q;
						rptr_q[w_q]          <= FILL_W'(rpos_q);
						last_q               <= best_q;
						out_kind             <= KIND_SHORT;
						out_res.delta_time   <= best_q - last_q;
						out_res.source_track <= src4(w_q);
						out_res.status_byte  <= stat_q;
						out_res.first_data   <= d1_q;
						out_valid            <= 1'b1;
						state_q              <= S_OUT;
					end else begin
						ret_q   <= S_XD2;
						state_q <= S_RD;
					end
				end
				S_XD2: begin
					rstat_q[w_q]         <= stat_q;
					ttime_q[w_q]         <= best_q;
					rptr_q[w_q]          <= FILL_W'(rpos_q + 1'b1);
					last_q               <= best_q;
					out_kind             <= KIND_SHORT;
					out_res.delta_time   <= best_q - last_q;
					out_res.source_track <= src4(w_q);
					out_res.status_byte  <= stat_q;
					out_res.first_data   <= d1_q;
					out_res.second_data  <= rdata_q;
					out_valid            <= 1'b1;
					state_q              <= S_OUT;
				end
				// meta length: tempo reads three bytes, others are skipped
				S_XLEN: begin
					if (bmeta_q == 8'h51) begin
						rpos_q  <= bpos_q + POS_W'(3);
						ret_q   <= S_XT0;
						state_q <= S_RD;
					end else if (skip_next > POS_W'(fill_q[w_q])) begin
						out_kind            <= KIND_ERR;
						out_res.source_track <= src4(w_q);
						out_valid           <= 1'b1;
						state_q             <= S_OUT;
					end else begin
						ttime_q[w_q] <= best_q;
						rptr_q[w_q]  <= FILL_W'(skip_next);
						cur_q        <= '0;
						found_q      <= 1'b0;
						state_q      <= S_PINIT;
					end
				end
				S_XT0: begin
					a0_q    <= rdata_q;
					rpos_q  <= rpos_q + 1'b1;
					ret_q   <= S_XT1;
					state_q <= S_RD;
				end
				S_XT1: begin
					a1_q    <= rdata_q;
					rpos_q  <= rpos_q + 1'b1;
					ret_q   <= S_XT2;
					state_q <= S_RD;
				end
				S_XT2: begin
					ttime_q[w_q]         <= best_q;
					rptr_q[w_q]          <= FILL_W'(bpos_q + POS_W'(6));
					last_q               <= best_q;
					out_kind             <= KIND_TEMPO;
					out_res.delta_time   <= best_q - last_q;
					out_res.source_track <= src4(w_q);
					out_res.tempo_value  <= {a0_q, a1_q, rdata_q};
					out_valid            <= 1'b1;
					state_q              <= S_OUT;
				end
				// hold the result until the transfer
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
